/* sv/nbuuid_pkg.sv */
package nbuuid_pkg;

   localparam int unsigned ROUNDS = 80;
   localparam int unsigned WINDOW = 16;
   localparam int unsigned BASE_LEN = 38;

   localparam logic [1:0] ACT_DEVICE = 2'd0;
   localparam logic [1:0] ACT_PART   = 2'd1;
   localparam logic [1:0] ACT_SUB    = 2'd2;

   localparam logic [5:0] LEN_DEVICE = 6'd38;
   localparam logic [5:0] LEN_PART   = 6'd50;
   localparam logic [5:0] LEN_SUB    = 6'd46;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [7:0] TAG_PART = 8'h0b;
   localparam logic [7:0] TAG_SUB  = 8'h07;

   localparam logic [303:0] BASE_MSG = {
      128'hc816c9a3_522456bf_9d9aac7e_a703fb5b,
      80'h4e56_4944_4941_2047_5055,
      8'h02, 16'h0000,
      8'h08, 64'h0000_0000_0000_0000
   };

   localparam logic [23:0] TEXT_PART = 24'h534d43;
   localparam logic [23:0] TEXT_SUB  = 24'h554743;

   localparam logic [31:0] H0_INIT = 32'h67452301;
   localparam logic [31:0] H1_INIT = 32'hefcdab89;
   localparam logic [31:0] H2_INIT = 32'h98badcfe;
   localparam logic [31:0] H3_INIT = 32'h10325476;
   localparam logic [31:0] H4_INIT = 32'hc3d2e1f0;

   localparam logic [31:0] K_CH  = 32'h5a827999;
   localparam logic [31:0] K_PA1 = 32'h6ed9eba1;
   localparam logic [31:0] K_MAJ = 32'h8f1bbcdc;
   localparam logic [31:0] K_PA2 = 32'hca62c1d6;

   localparam logic [6:0] ROUND_LAST = 7'(ROUNDS - 1);
   localparam logic [6:0] ROUND_PA1  = 7'd20;
   localparam logic [6:0] ROUND_MAJ  = 7'd40;
   localparam logic [6:0] ROUND_PA2  = 7'd60;

   localparam logic [3:0] VERSION_NIBBLE = 4'h5;
   localparam logic [1:0] VARIANT_BITS   = 2'b10;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic [31:0] e;
   } sha1_state_type;

   typedef struct packed {
      logic load;
      logic advance;
   } sched_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_ROUND  = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   function automatic logic [31:0] rotl1(input logic [31:0] x);
      return {x[30:0], x[31]};
   endfunction

endpackage

/* sv/nbuuid_msg.sv */
module nbuuid_msg
   import nbuuid_pkg::*;
(
   input  logic [1:0]   action,
   input  logic [15:0]  chip_id,
   input  logic [63:0]  device_identifier,
   input  logic [31:0]  swizzle_id,
   input  logic [31:0]  syspipe_id,
   input  logic [31:0]  ugpu_id,
   output logic [511:0] block
);

   logic [7:0]  blk [64];
   logic [5:0]  msg_len;
   logic [15:0] bit_len;

   always_comb begin
      for (int i = 0; i < BASE_LEN; i++) begin
         blk[i] = BASE_MSG[8*(BASE_LEN-1-i) +: 8];
      end
      for (int i = BASE_LEN; i < 64; i++) begin
         blk[i] = 8'h00;
      end
      blk[27] = chip_id[7:0];
      blk[28] = chip_id[15:8];
      for (int j = 0; j < 8; j++) begin
         blk[30+j] = device_identifier[8*j +: 8];
      end
      case (action)
         ACT_PART: begin
            blk[38] = TAG_PART;
            blk[39] = TEXT_PART[23:16];
            blk[40] = TEXT_PART[15:8];
            blk[41] = TEXT_PART[7:0];
            for (int j = 0; j < 4; j++) begin
               blk[42+j] = swizzle_id[8*j +: 8];
               blk[46+j] = syspipe_id[8*j +: 8];
            end
            msg_len = LEN_PART;
         end
         ACT_SUB: begin
            blk[38] = TAG_SUB;
            blk[39] = TEXT_SUB[23:16];
            blk[40] = TEXT_SUB[15:8];
            blk[41] = TEXT_SUB[7:0];
            for (int j = 0; j < 4; j++) begin
               blk[42+j] = ugpu_id[8*j +: 8];
            end
            msg_len = LEN_SUB;
         end
         default: begin
            msg_len = LEN_DEVICE;
         end
      endcase
      blk[msg_len] = PAD_MARK;
      bit_len = {7'd0, msg_len, 3'd0};
      blk[62] = bit_len[15:8];
      blk[63] = bit_len[7:0];
      for (int i = 0; i < 64; i++) begin
         block[511-8*i -: 8] = blk[i];
      end
   end

endmodule

/* sv/nbuuid_sched.sv */
module nbuuid_sched
   import nbuuid_pkg::*;
(
   input  logic           clock,
   input  sched_ctrl_type ctrl,
   input  logic [511:0]   block,
   output logic [31:0]    w_cur
);

   logic [31:0] w_ff [WINDOW];
   logic [31:0] w_in [WINDOW];

   always_comb begin
      for (int i = 0; i < WINDOW; i++) begin
         w_in[i] = w_ff[i];
      end
      if (ctrl.load) begin
         for (int i = 0; i < WINDOW; i++) begin
            w_in[i] = block[511-32*i -: 32];
         end
      end else if (ctrl.advance) begin
         for (int i = 0; i < WINDOW-1; i++) begin
            w_in[i] = w_ff[i+1];
         end
         w_in[WINDOW-1] = rotl1(w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WINDOW; i++) begin
         w_ff[i] <= w_in[i];
      end
   end

   assign w_cur = w_ff[0];

endmodule

/* sv/nbuuid_round.sv */
module nbuuid_round
   import nbuuid_pkg::*;
(
   input  sha1_state_type cur,
   input  logic [6:0]     round,
   input  logic [31:0]    w,
   output sha1_state_type nxt
);

   logic [31:0] f;
   logic [31:0] k;

   always_comb begin
      if (round < ROUND_PA1) begin
         f = (cur.b & cur.c) | (~cur.b & cur.d);
         k = K_CH;
      end else if (round < ROUND_MAJ) begin
         f = cur.b ^ cur.c ^ cur.d;
         k = K_PA1;
      end else if (round < ROUND_PA2) begin
         f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
         k = K_MAJ;
      end else begin
         f = cur.b ^ cur.c ^ cur.d;
         k = K_PA2;
      end
      nxt.a = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w;
      nxt.b = cur.a;
      nxt.c = {cur.b[1:0], cur.b[31:2]};
      nxt.d = cur.c;
      nxt.e = cur.d;
   end

endmodule

/* sv/name_based_uuid_sha1.sv */
// An accepted request runs 80 SHA-1 rounds, then the digest add, before rsp_valid.
// One SHA-1 round unit is reused, one round per cycle; the next request waits for idle.
// req_ready is high only while idle; a finished result waits in the output register.
// Reset (synchronous, active high) returns the sequencer to idle and drops rsp_valid.
module name_based_uuid_sha1
   import nbuuid_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_chip_id,
   input  logic [63:0] req_device_identifier,
   input  logic [31:0] req_swizzle_id,
   input  logic [31:0] req_syspipe_id,
   input  logic [31:0] req_ugpu_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_uuid_first_half,
   output logic [63:0] rsp_uuid_second_half
);

   state_type      state_ff, state_in;
   logic [6:0]     round_ff, round_in;
   sha1_state_type hash_ff, hash_in, hash_nxt;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [63:0]    first_ff, first_in;
   logic [63:0]    second_ff, second_in;
   logic [511:0]   block;
   logic [31:0]    w_cur;
   sched_ctrl_type sched_ctrl;
   logic           req_take;
   logic           rsp_take;
   logic           finish_go;
   logic [31:0]    sum0, sum1, sum2, sum3;

   nbuuid_msg u_msg (
      .action            (req_action),
      .chip_id           (req_chip_id),
      .device_identifier (req_device_identifier),
      .swizzle_id        (req_swizzle_id),
      .syspipe_id        (req_syspipe_id),
      .ugpu_id           (req_ugpu_id),
      .block             (block)
   );

   nbuuid_sched u_sched (
      .clock (clock),
      .ctrl  (sched_ctrl),
      .block (block),
      .w_cur (w_cur)
   );

   nbuuid_round u_round (
      .cur   (hash_ff),
      .round (round_ff),
      .w     (w_cur),
      .nxt   (hash_nxt)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rsp_take  = rsp_valid_ff && rsp_ready;
   assign finish_go = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   assign sched_ctrl.load    = req_take;
   assign sched_ctrl.advance = (state_ff == ST_ROUND);

   assign sum0 = hash_ff.a + H0_INIT;
   assign sum1 = hash_ff.b + H1_INIT;
   assign sum2 = hash_ff.c + H2_INIT;
   assign sum3 = hash_ff.d + H3_INIT;

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      hash_in      = hash_ff;
      rsp_valid_in = rsp_valid_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               hash_in  = '{a: H0_INIT, b: H1_INIT, c: H2_INIT, d: H3_INIT, e: H4_INIT};
               round_in = 7'd0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            hash_in  = hash_nxt;
            round_in = round_ff + 7'd1;
            if (round_ff == ROUND_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish_go) begin
               first_in     = {sum0, sum1[31:16], VERSION_NIBBLE, sum1[11:0]};
               second_in    = {VARIANT_BITS, sum2[29:0], sum3};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         round_ff     <= 7'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         round_ff     <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff   <= hash_in;
      first_ff  <= first_in;
      second_ff <= second_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_uuid_first_half  = first_ff;
   assign rsp_uuid_second_half = second_ff;

`ifndef ASSERT_OFF
   a_onehot_state: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_start_round: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_ROUND) && (round_ff == 7'd0))
      else $error("accepted request did not start at round zero");

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (round_ff <= ROUND_LAST))
      else $error("round counter out of range");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside finish step");
`endif

endmodule

/* verif/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import nbuuid_pkg::*;

   localparam logic [1:0]   ACT_UNUSED   = 2'd3;
   localparam logic [127:0] NAMESPACE    = 128'hc816c9a3_522456bf_9d9aac7e_a703fb5b;
   localparam logic [79:0]  PRODUCT_TEXT = 80'h4e56_4944_4941_2047_5055;
   localparam logic [7:0]   CHIP_TAG     = 8'h02;
   localparam logic [7:0]   DEVICE_TAG   = 8'h08;
   localparam logic [7:0]   PART_TAG     = 8'h0b;
   localparam logic [7:0]   SUB_TAG      = 8'h07;
   localparam logic [23:0]  PART_TEXT    = 24'h534d43;
   localparam logic [23:0]  SUB_TEXT     = 24'h554743;
   localparam logic [7:0]   PAD_BYTE     = 8'h80;
   localparam int           HOLD_CYCLES  = 400;

   class uuid_tracker;
      logic [127:0] pending_uuids[$];
      int checked;
      int errors;
      int kinds_seen[4];

      function logic [31:0] rotate_left(logic [31:0] x, int n);
         return (x << n) | (x >> (32 - n));
      endfunction

      function logic [127:0] uuid_v5_of(logic [1:0] act, logic [15:0] chip,
                                        logic [63:0] dev, logic [31:0] swz,
                                        logic [31:0] pipe, logic [31:0] ugpu);
         logic [7:0]  m [64];
         logic [31:0] w [80];
         logic [31:0] h [5];
         logic [31:0] a, b, c, d, e, f, k, t;
         logic [63:0] first, second;
         logic [15:0] bits;
         int len;
         foreach (m[i]) m[i] = 8'h00;
         for (int i = 0; i < 16; i++) m[i] = NAMESPACE[127 - 8 * i -: 8];
         for (int i = 0; i < 10; i++) m[16 + i] = PRODUCT_TEXT[79 - 8 * i -: 8];
         m[26] = CHIP_TAG;
         m[27] = chip[7:0];
         m[28] = chip[15:8];
         m[29] = DEVICE_TAG;
         for (int i = 0; i < 8; i++) m[30 + i] = dev[8 * i +: 8];
         len = 38;
         if (act == ACT_PART) begin
            m[38] = PART_TAG;
            for (int i = 0; i < 3; i++) m[39 + i] = PART_TEXT[23 - 8 * i -: 8];
            for (int i = 0; i < 4; i++) begin
               m[42 + i] = swz[8 * i +: 8];
               m[46 + i] = pipe[8 * i +: 8];
            end
            len = 50;
         end else if (act == ACT_SUB) begin
            m[38] = SUB_TAG;
            for (int i = 0; i < 3; i++) m[39 + i] = SUB_TEXT[23 - 8 * i -: 8];
            for (int i = 0; i < 4; i++) m[42 + i] = ugpu[8 * i +: 8];
            len = 46;
         end
         m[len] = PAD_BYTE;
         bits = 16'(len * 8);
         m[62] = bits[15:8];
         m[63] = bits[7:0];

         h[0] = 32'h67452301;
         h[1] = 32'hefcdab89;
         h[2] = 32'h98badcfe;
         h[3] = 32'h10325476;
         h[4] = 32'hc3d2e1f0;
         for (int i = 0; i < 16; i++) w[i] = {m[4 * i], m[4 * i + 1], m[4 * i + 2], m[4 * i + 3]};
         for (int i = 16; i < 80; i++)
            w[i] = rotate_left(w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16], 1);
         a = h[0];
         b = h[1];
         c = h[2];
         d = h[3];
         e = h[4];
         for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
               f = (b & c) | (~b & d);
               k = 32'h5a827999;
            end else if (i < 40) begin
               f = b ^ c ^ d;
               k = 32'h6ed9eba1;
            end else if (i < 60) begin
               f = (b & c) | (b & d) | (c & d);
               k = 32'h8f1bbcdc;
            end else begin
               f = b ^ c ^ d;
               k = 32'hca62c1d6;
            end
            t = rotate_left(a, 5) + f + e + k + w[i];
            e = d;
            d = c;
            c = rotate_left(b, 30);
            b = a;
            a = t;
         end
         first = {h[0] + a, h[1] + b};
         second = {h[2] + c, h[3] + d};
         first[15:12] = 4'h5;
         second[63:62] = 2'b10;
         return {first, second};
      endfunction

      function void note_request(logic [1:0] act, logic [15:0] chip, logic [63:0] dev,
                                 logic [31:0] swz, logic [31:0] pipe, logic [31:0] ugpu);
         pending_uuids.push_back(uuid_v5_of(act, chip, dev, swz, pipe, ugpu));
         kinds_seen[act]++;
      endfunction

      function void check_uuid(logic [63:0] first, logic [63:0] second);
         logic [127:0] want;
         if (pending_uuids.size() == 0) begin
            $error("uuid result with no request outstanding: %h %h", first, second);
            errors++;
         end else begin
            want = pending_uuids.pop_front();
            checked++;
            if (first !== want[127:64]) begin
               $error("uuid_first_half: expected %h, actual %h", want[127:64], first);
               errors++;
            end
            if (second !== want[63:0]) begin
               $error("uuid_second_half: expected %h, actual %h", want[63:0], second);
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_action;
   logic [15:0] req_chip_id;
   logic [63:0] req_device_identifier;
   logic [31:0] req_swizzle_id;
   logic [31:0] req_syspipe_id;
   logic [31:0] req_ugpu_id;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_uuid_first_half;
   logic [63:0] rsp_uuid_second_half;

   uuid_tracker board = new();
   bit paced = 1'b1;
   bit hold_rsp = 1'b0;

   name_based_uuid_sha1 dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 64'h0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic send_request(input logic [1:0] act, input logic [15:0] chip,
                               input logic [63:0] dev, input logic [31:0] swz,
                               input logic [31:0] pipe, input logic [31:0] ugpu);
      int gap;
      gap = paced ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_chip_id <= chip;
      req_device_identifier <= dev;
      req_swizzle_id <= swz;
      req_syspipe_id <= pipe;
      req_ugpu_id <= ugpu;
      do @(posedge clock); while (!req_ready);
      board.note_request(act, chip, dev, swz, pipe, ugpu);
   endtask

   task automatic send_random();
      logic [63:0] chip, dev, swz, pipe, ugpu;
      logic [1:0] act;
      act = ($urandom_range(0, 15) == 0) ? ACT_UNUSED : 2'($urandom_range(0, 2));
      chip = pick_value();
      dev = pick_value();
      swz = pick_value();
      pipe = pick_value();
      ugpu = pick_value();
      send_request(act, chip[15:0], dev, swz[31:0], pipe[31:0], ugpu[31:0]);
   endtask

   task automatic drain_uuids();
      req_valid <= 1'b0;
      while (board.pending_uuids.size() != 0) @(posedge clock);
   endtask

   initial begin
      int stall;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp) begin
            stall = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end else begin
            stall = paced ? $urandom_range(0, 14) : 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         board.check_uuid(rsp_uuid_first_half, rsp_uuid_second_half);
      end
   end

   initial begin
      logic [63:0] pattern [4];
      int waited;
      pattern[0] = 64'h0;
      pattern[1] = '1;
      pattern[2] = {4{16'h5555}};
      pattern[3] = {4{16'haaaa}};
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_action <= ACT_DEVICE;
      req_chip_id <= '0;
      req_device_identifier <= '0;
      req_swizzle_id <= '0;
      req_syspipe_id <= '0;
      req_ugpu_id <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int p = 0; p < 4; p++)
         for (int kind = 0; kind < 4; kind++)
            send_request(2'(kind), pattern[p][15:0], pattern[p], pattern[p][31:0],
                         pattern[p][31:0], pattern[p][31:0]);
      // unused fields must not leak into the message
      send_request(ACT_SUB, 16'h1234, 64'h0123_4567_89ab_cdef, '1, '1, '0);
      send_request(ACT_PART, 16'h1234, 64'h0123_4567_89ab_cdef, '0, '0, '1);
      drain_uuids();

      repeat (450) send_random();

      // hold results back while requests keep coming
      hold_rsp = 1'b1;
      paced = 1'b0;
      repeat (12) send_random();
      drain_uuids();

      repeat (250) send_random();
      paced = 1'b1;
      repeat (520) send_random();
      req_valid <= 1'b0;

      waited = 0;
      while (board.pending_uuids.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (200) @(posedge clock);
      if (board.pending_uuids.size() != 0) begin
         $error("%0d uuid results never arrived", board.pending_uuids.size());
         board.errors++;
      end

      $display("Checked %0d uuids: %0d device, %0d partition, %0d sub-die, %0d unused kind",
               board.checked, board.kinds_seen[0], board.kinds_seen[1],
               board.kinds_seen[2], board.kinds_seen[3]);
      $display("Ran random gaps on both sides, back-to-back bursts and a long result hold-off");
      if (board.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
